### hdl/fsol_pkg.sv
// fsol_pkg: shared constants, register map and fan state codes for the
// fan stage and overheat lockout unit
// no dependencies
package fsol_pkg;

   // default geometry, handed to the top level as parameter defaults
   localparam int NUM_MODULES_DEF     = 4;
   localparam int PINS_PER_MODULE_DEF = 4;
   localparam int TEMP_WIDTH_DEF      = 12;

   // fixed field widths
   localparam int FAN_W  = 2;
   localparam int GATE_W = 14;
   localparam int PCT_W  = 7;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // register reset values (1/16 degree C, percent)
   localparam int RST_STAGE1_ON  = 640;
   localparam int RST_STAGE1_OFF = 560;
   localparam int RST_STAGE2_ON  = 800;
   localparam int RST_STAGE2_OFF = 720;
   localparam int RST_OVERHEAT   = 1120;
   localparam int RST_HYST       = 160;
   localparam int RST_SPEED_PCT  = 50;

   // triac gate delay: base + step * (full - pct)
   localparam int GATE_BASE_US = 200;
   localparam int GATE_STEP_US = 96;
   localparam int PCT_FULL     = 100;

   // register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_STAGE1_ON  = 3'd0,
      REG_STAGE1_OFF = 3'd1,
      REG_STAGE2_ON  = 3'd2,
      REG_STAGE2_OFF = 3'd3,
      REG_OVERHEAT   = 3'd4,
      REG_HYST       = 3'd5,
      REG_SPEED_PCT  = 3'd6
   } csr_reg_type;

   // fan state machine, one-hot
   typedef enum logic [2:0] {
      FAN_OFF   = 3'b001,
      FAN_PHASE = 3'b010,
      FAN_FULL  = 3'b100
   } fan_state_type;

   // fan_stage codes on the result word
   localparam logic [FAN_W-1:0] STAGE_OFF   = 2'd0;
   localparam logic [FAN_W-1:0] STAGE_PHASE = 2'd1;
   localparam logic [FAN_W-1:0] STAGE_FULL  = 2'd2;

endpackage

### hdl/fsol_hot_pick.sv
// fsol_hot_pick: picks the hottest module of one tick, lowest index on ties,
// a faulted reading fails every compare; no package dependencies
module fsol_hot_pick #(
   parameter int NUM_MODULES = 4,
   parameter int TEMP_WIDTH  = 12
) (
   input  logic [NUM_MODULES*TEMP_WIDTH-1:0] temps,
   input  logic [NUM_MODULES-1:0]            fault,
   output logic [$clog2(NUM_MODULES)-1:0]    hot_idx,
   output logic signed [TEMP_WIDTH-1:0]      hot_temp,
   output logic                              hot_valid
);

   localparam int HOT_W = $clog2(NUM_MODULES);

   // linear scan, moves only when both candidates are valid and strictly hotter
   always_comb begin
      logic signed [TEMP_WIDTH-1:0] cur_t;
      logic signed [TEMP_WIDTH-1:0] cand_t;
      logic                         cur_ok;
      logic [HOT_W-1:0]             idx;
      cur_t  = $signed(temps[TEMP_WIDTH-1:0]);
      cur_ok = !fault[0];
      idx    = '0;
      for (int i = 1; i < NUM_MODULES; i++) begin
         cand_t = $signed(temps[i*TEMP_WIDTH +: TEMP_WIDTH]);
         if (cur_ok && !fault[i] && (cand_t > cur_t)) begin
            idx   = HOT_W'(i);
            cur_t = cand_t;
         end
      end
      hot_idx   = idx;
      hot_valid = cur_ok;
      hot_temp  = cur_ok ? cur_t : '0;
   end

endmodule

### hdl/fan_stage_and_overheat_lockout_unit.sv
// fan_stage_and_overheat_lockout_unit: top level, input and result registers,
// fan state machine, module lockout and configuration registers
// depends on fsol_pkg and fsol_hot_pick
//
// usage
//   req channel: one word per control tick, four module temperatures in
//   1/16 degree C, per-module sensor fault bits and the current pin levels.
//   rsp channel: one word per tick, fan stage, triac gate delay, lock state,
//   lock and unlock events, pin write mask and levels, hottest module.
//   csr port: apb-style, seven registers at byte address 4*i, written with a
//   setup and an access cycle, pready always high; write only while idle.
// pipeline
//   a word is registered at the input, processed in one pass and lands in the
//   result register. one word per cycle is sustained while rsp_tready stays
//   high, set by the single pass between the two registers.
// reset
//   synchronous, active high: fan off, no module locked, both stages empty,
//   registers back to their defaults.
// backpressure
//   when rsp_tready is low the result word holds; the input stage still takes
//   one more word, then req_tready drops until the result is taken.
module fan_stage_and_overheat_lockout_unit
   import fsol_pkg::*;
#(
   parameter int NUM_MODULES     = NUM_MODULES_DEF,
   parameter int PINS_PER_MODULE = PINS_PER_MODULE_DEF,
   parameter int TEMP_WIDTH      = TEMP_WIDTH_DEF,
   localparam int PIN_W  = NUM_MODULES * PINS_PER_MODULE,
   localparam int HOT_W  = $clog2(NUM_MODULES),
   localparam int IN_RAW = NUM_MODULES * TEMP_WIDTH + NUM_MODULES + PIN_W,
   localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
   localparam int OUT_RAW = FAN_W + GATE_W + 3 * NUM_MODULES + 2 * PIN_W + HOT_W
                            + TEMP_WIDTH + 1,
   localparam int OUT_W  = ((OUT_RAW + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // req word: temp_0 .. temp_N-1, sensor_fault, pin_states
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_W-1:0]       req_tdata,
   // rsp word: fan_stage, gate_delay_us, locked_flags, lock_event,
   // unlock_event, pin_write_mask, pin_write_value, hot_module, hot_temp,
   // hot_valid
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int HYST_W = TEMP_WIDTH - 1;

   // configuration registers
   logic signed [TEMP_WIDTH-1:0] s1_on_ff, s1_off_ff, s2_on_ff, s2_off_ff, limit_ff;
   logic [HYST_W-1:0]            hyst_ff;
   logic [PCT_W-1:0]             pct_ff;
   logic                         csr_wr;
   csr_reg_type                  csr_reg;

   // pipeline registers
   logic                         in_valid_ff;
   logic [IN_RAW-1:0]            in_data_ff;
   logic                         out_valid_ff;
   logic [OUT_W-1:0]             out_data_ff;
   logic [OUT_W-1:0]             out_data_in;
   logic                         adv;

   // block state
   fan_state_type                fan_ff, fan_in;
   logic [NUM_MODULES-1:0]       locked_ff, locked_in;
   logic [PINS_PER_MODULE-1:0]   saved_ff [NUM_MODULES];

   // per-word signals
   logic [NUM_MODULES*TEMP_WIDTH-1:0] in_temps;
   logic [NUM_MODULES-1:0]       in_fault;
   logic [PIN_W-1:0]             in_pins;
   logic [HOT_W-1:0]             hot_idx;
   logic signed [TEMP_WIDTH-1:0] hot_temp;
   logic                         hot_valid;
   logic [NUM_MODULES-1:0]       lock_ev, unlock_ev, locked_mid;
   logic [PIN_W-1:0]             wmask, wval;
   logic signed [TEMP_WIDTH:0]   restore_at;
   logic [PCT_W-1:0]             pct_clamp, pct_left;
   logic [GATE_W-1:0]            gate_delay;
   logic [FAN_W-1:0]             fan_code;

   // configuration write and readback
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_on_ff  <= TEMP_WIDTH'(RST_STAGE1_ON);
         s1_off_ff <= TEMP_WIDTH'(RST_STAGE1_OFF);
         s2_on_ff  <= TEMP_WIDTH'(RST_STAGE2_ON);
         s2_off_ff <= TEMP_WIDTH'(RST_STAGE2_OFF);
         limit_ff  <= TEMP_WIDTH'(RST_OVERHEAT);
         hyst_ff   <= HYST_W'(RST_HYST);
         pct_ff    <= PCT_W'(RST_SPEED_PCT);
      end else if (csr_wr) begin
         unique case (csr_reg)
            REG_STAGE1_ON:  s1_on_ff  <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_STAGE1_OFF: s1_off_ff <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_STAGE2_ON:  s2_on_ff  <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_STAGE2_OFF: s2_off_ff <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_OVERHEAT:   limit_ff  <= csr_pwdata[TEMP_WIDTH-1:0];
            REG_HYST:       hyst_ff   <= csr_pwdata[HYST_W-1:0];
            REG_SPEED_PCT:  pct_ff    <= csr_pwdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_STAGE1_ON:  csr_prdata = CSR_DATA_W'(s1_on_ff);
         REG_STAGE1_OFF: csr_prdata = CSR_DATA_W'(s1_off_ff);
         REG_STAGE2_ON:  csr_prdata = CSR_DATA_W'(s2_on_ff);
         REG_STAGE2_OFF: csr_prdata = CSR_DATA_W'(s2_off_ff);
         REG_OVERHEAT:   csr_prdata = CSR_DATA_W'(limit_ff);
         REG_HYST:       csr_prdata = CSR_DATA_W'(hyst_ff);
         REG_SPEED_PCT:  csr_prdata = CSR_DATA_W'(pct_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // handshake: the input stage moves on when the result register is free
   assign adv        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[IN_RAW-1:0];
      end
   end

   // unpack the input word
   assign in_temps = in_data_ff[NUM_MODULES*TEMP_WIDTH-1:0];
   assign in_fault = in_data_ff[NUM_MODULES*TEMP_WIDTH +: NUM_MODULES];
   assign in_pins  = in_data_ff[NUM_MODULES*TEMP_WIDTH+NUM_MODULES +: PIN_W];

   // hottest module
   fsol_hot_pick #(
      .NUM_MODULES (NUM_MODULES),
      .TEMP_WIDTH  (TEMP_WIDTH)
   ) u_hot_pick (
      .temps     (in_temps),
      .fault     (in_fault),
      .hot_idx   (hot_idx),
      .hot_temp  (hot_temp),
      .hot_valid (hot_valid)
   );

   // fan stage with hysteresis, held while the hottest reading is invalid
   always_comb begin
      fan_in = fan_ff;
      if (hot_valid) begin
         unique case (fan_ff)
            FAN_PHASE: begin
               if (hot_temp >= s2_on_ff) begin
                  fan_in = FAN_FULL;
               end else if (hot_temp <= s1_off_ff) begin
                  fan_in = FAN_OFF;
               end
            end
            FAN_FULL: begin
               if (hot_temp <= s2_off_ff) begin
                  fan_in = FAN_PHASE;
               end
            end
            FAN_OFF:  fan_in = (hot_temp >= s1_on_ff) ? FAN_PHASE : FAN_OFF;
            default:  fan_in = (hot_temp >= s1_on_ff) ? FAN_PHASE : FAN_OFF;
         endcase
      end
   end

   always_comb begin
      unique case (fan_in)
         FAN_PHASE: fan_code = STAGE_PHASE;
         FAN_FULL:  fan_code = STAGE_FULL;
         default:   fan_code = STAGE_OFF;
      endcase
   end

   // lock the hottest module at the limit if not yet locked, then restore any
   // locked module that has cooled; a module locked this tick restores its new save
   assign restore_at = $signed({limit_ff[TEMP_WIDTH-1], limit_ff})
                     - $signed({2'b00, hyst_ff});

   always_comb begin
      logic signed [TEMP_WIDTH:0]   t_ext;
      logic [PINS_PER_MODULE-1:0]   grp_pins;
      logic [PINS_PER_MODULE-1:0]   grp_saved;
      for (int m = 0; m < NUM_MODULES; m++) begin
         lock_ev[m] = hot_valid && (hot_temp >= limit_ff) && !locked_ff[hot_idx]
                      && (hot_idx == HOT_W'(m));
      end
      locked_mid = locked_ff | lock_ev;
      for (int m = 0; m < NUM_MODULES; m++) begin
         t_ext     = $signed({in_temps[m*TEMP_WIDTH+TEMP_WIDTH-1],
                              in_temps[m*TEMP_WIDTH +: TEMP_WIDTH]});
         grp_pins  = in_pins[m*PINS_PER_MODULE +: PINS_PER_MODULE];
         grp_saved = lock_ev[m] ? grp_pins : saved_ff[m];
         unlock_ev[m] = locked_mid[m] && !in_fault[m] && (t_ext <= restore_at);
         wmask[m*PINS_PER_MODULE +: PINS_PER_MODULE] = {PINS_PER_MODULE{lock_ev[m] |
                                                                      unlock_ev[m]}};
         wval[m*PINS_PER_MODULE +: PINS_PER_MODULE]  = unlock_ev[m] ? grp_saved : '0;
      end
      locked_in = locked_mid & ~unlock_ev;
   end

   // gate delay from the stage-one speed, clamped to full speed
   assign pct_clamp  = (pct_ff > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_ff;
   assign pct_left   = PCT_W'(PCT_FULL) - pct_clamp;
   assign gate_delay = GATE_W'(GATE_BASE_US) + GATE_W'(pct_left) * GATE_W'(GATE_STEP_US);

   // pack the result word
   assign out_data_in = OUT_W'({hot_valid, hot_temp, hot_idx, wval, wmask, unlock_ev,
                                lock_ev, locked_in, gate_delay, fan_code});

   // state update, one step per word
   always_ff @(posedge clock) begin
      if (reset) begin
         fan_ff    <= FAN_OFF;
         locked_ff <= '0;
      end else if (adv) begin
         fan_ff    <= fan_in;
         locked_ff <= locked_in;
      end
   end

   // saved pin levels, written when a module is locked
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int m = 0; m < NUM_MODULES; m++) begin
            if (lock_ev[m]) begin
               saved_ff[m] <= in_pins[m*PINS_PER_MODULE +: PINS_PER_MODULE];
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
